>>> rtl/hbx_pkg.sv
// package for the http body extractor: header scan state, character codes
// and the range tag lookup; no dependencies
`timescale 1ns / 1ps

package hbx_pkg;

    // characters seen in the response header
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] ASCII_ZERO = 8'd48;

    // length of the "-Range:" tag
    localparam logic [3:0] RANGE_TAG_LEN = 4'd7;

    // reset value of the flash base register
    localparam logic [23:0] FLASH_BASE_RESET = 24'h010000;

    // position inside the range line
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SKIP  = 2'd1,
        PH_SLASH = 2'd2,
        PH_LEN   = 2'd3
    } range_phase_t;

    typedef struct packed {
        logic [31:0]  length_accum;
        logic [2:0]   range_match_count;
        range_phase_t range_line_phase;
        logic [1:0]   end_match_count;
    } hdr_state_t;

    // one character of "-Range:"
    function automatic logic [7:0] range_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CHAR_DASH;
            3'd1:    c = 8'h52;
            3'd2:    c = 8'h61;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h67;
            3'd5:    c = 8'h65;
            3'd6:    c = 8'h3A;
            default: c = CHAR_DASH;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/http_body_extract_word_checksum_core.sv
// top level of the http body extractor with flash addressing and word checksum
// depends on hbx_pkg and hbx_hdr_scan
`timescale 1ns / 1ps

// Takes one response byte per transfer and returns one result per byte. Each
// accepted byte sits in an input register; combinational logic (header scan,
// length multiply-add by ten, address add, checksum add, length compare)
// produces the result into an output register, so a byte can be accepted
// every cycle unless a full output register is held by a low out_ready.
// in_ready stays high while the output register is free or being drained.
// Header bytes report is_body low with zero address, data and word_done.
// After CR LF CR LF every byte is body data until the next response_start.
// Body bytes get address flash_base + body count and are packed little
// endian into 32-bit words summed into a wrapping checksum; body count and
// checksum persist across responses until update_start. flash_base is
// written by cfg_wr_en / cfg_wr_data and should only change while idle.
module http_body_extract_word_checksum_core
    import hbx_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_wr_en,
    input  logic [23:0] cfg_wr_data,
    // byte input
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        response_start,
    input  logic        update_start,
    // result output
    output logic        out_valid,
    input  logic        out_ready,
    output logic        is_body,
    output logic        burst_start,
    output logic [31:0] write_address,
    output logic [7:0]  write_data,
    output logic        word_done,
    output logic [31:0] running_sum,
    output logic        sum_is_zero,
    output logic [31:0] total_length,
    output logic        more_needed
);

    // control and state
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic [23:0] flash_base_reg;
    logic        in_body_reg,  in_body_next;
    logic        first_body_pending_reg, first_body_pending_next;
    hdr_state_t  hdr_reg, hdr_next;
    logic [31:0] body_count_reg, body_count_next;
    logic [23:0] partial_word_reg, partial_word_next;
    logic [31:0] word_sum_reg, word_sum_next;

    // input payload register
    logic [7:0]  data_byte_reg;
    logic        response_start_reg;
    logic        update_start_reg;

    // output payload registers
    logic        is_body_reg, is_body_next;
    logic        burst_start_reg, burst_start_next;
    logic [31:0] write_address_reg, write_address_next;
    logic [7:0]  write_data_reg, write_data_next;
    logic        word_done_reg, word_done_next;
    logic        more_needed_reg, more_needed_next;

    // state after the start flags are applied
    hdr_state_t  hdr_cur;
    logic        in_body_cur;
    logic        first_body_pending_cur;
    logic [31:0] body_count_cur;
    logic [23:0] partial_word_cur;
    logic [31:0] word_sum_cur;

    hdr_state_t  hdr_scanned;
    logic        enter_body;
    logic        advance;
    logic        in_xfer;

    // item moves from input register to output register
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // update_start clears the counters, response_start restarts the header scan
    always_comb
    begin
        body_count_cur         = update_start_reg ? 32'd0 : body_count_reg;
        partial_word_cur       = update_start_reg ? 24'd0 : partial_word_reg;
        word_sum_cur           = update_start_reg ? 32'd0 : word_sum_reg;
        hdr_cur                = response_start_reg ? '0 : hdr_reg;
        in_body_cur            = response_start_reg ? 1'b0 : in_body_reg;
        first_body_pending_cur = response_start_reg ? 1'b1 : first_body_pending_reg;
    end

    hbx_hdr_scan u_hdr_scan (
        .data_byte  (data_byte_reg),
        .cur        (hdr_cur),
        .nxt        (hdr_scanned),
        .enter_body (enter_body)
    );

    // body path: address, lane packing, checksum
    always_comb
    begin
        in_body_next            = in_body_cur;
        first_body_pending_next = first_body_pending_cur;
        hdr_next                = hdr_cur;
        body_count_next         = body_count_cur;
        partial_word_next       = partial_word_cur;
        word_sum_next           = word_sum_cur;
        is_body_next            = 1'b0;
        burst_start_next        = 1'b0;
        write_address_next      = 32'd0;
        write_data_next         = 8'd0;
        word_done_next          = 1'b0;
        if (in_body_cur)
        begin
            is_body_next            = 1'b1;
            burst_start_next        = first_body_pending_cur;
            first_body_pending_next = 1'b0;
            write_address_next      = {8'd0, flash_base_reg} + body_count_cur;
            write_data_next         = data_byte_reg;
            case (body_count_cur[1:0])
                2'd0:    partial_word_next = {16'd0, data_byte_reg};
                2'd1:    partial_word_next = {8'd0, data_byte_reg, partial_word_cur[7:0]};
                2'd2:    partial_word_next = {data_byte_reg, partial_word_cur[15:0]};
                default:
                begin
                    word_sum_next  = word_sum_cur + {data_byte_reg, partial_word_cur};
                    word_done_next = 1'b1;
                end
            endcase
            body_count_next = body_count_cur + 32'd1;
        end
        else
        begin
            hdr_next     = hdr_scanned;
            in_body_next = enter_body;
        end
        more_needed_next = body_count_next < hdr_next.length_accum;
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg           <= 1'b0;
            out_valid_reg          <= 1'b0;
            flash_base_reg         <= FLASH_BASE_RESET;
            in_body_reg            <= 1'b0;
            first_body_pending_reg <= 1'b1;
            hdr_reg                <= '0;
            body_count_reg         <= 32'd0;
            partial_word_reg       <= 24'd0;
            word_sum_reg           <= 32'd0;
        end
        else
        begin
            if (cfg_wr_en)
                flash_base_reg <= cfg_wr_data;
            if (in_xfer)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (advance)
            begin
                in_body_reg            <= in_body_next;
                first_body_pending_reg <= first_body_pending_next;
                hdr_reg                <= hdr_next;
                body_count_reg         <= body_count_next;
                partial_word_reg       <= partial_word_next;
                word_sum_reg           <= word_sum_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            data_byte_reg      <= data_byte;
            response_start_reg <= response_start;
            update_start_reg   <= update_start;
        end
        if (advance)
        begin
            is_body_reg       <= is_body_next;
            burst_start_reg   <= burst_start_next;
            write_address_reg <= write_address_next;
            write_data_reg    <= write_data_next;
            word_done_reg     <= word_done_next;
            more_needed_reg   <= more_needed_next;
        end
    end

    // checksum and length outputs come straight from the state, which
    // only moves together with the output register
    assign out_valid     = out_valid_reg;
    assign is_body       = is_body_reg;
    assign burst_start   = burst_start_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign word_done     = word_done_reg;
    assign running_sum   = word_sum_reg;
    assign sum_is_zero   = (word_sum_reg == 32'd0);
    assign total_length  = hdr_reg.length_accum;
    assign more_needed   = more_needed_reg;

endmodule

>>> rtl/hbx_hdr_scan.sv
// header scanner: range tag match, length parse and end-of-header detect
// depends on hbx_pkg
`timescale 1ns / 1ps

module hbx_hdr_scan
    import hbx_pkg::*;
(
    input  logic [7:0] data_byte,
    input  hdr_state_t cur,
    output hdr_state_t nxt,
    output logic       enter_body
);

    logic [7:0]  em_want;
    logic [2:0]  em_inc;
    logic [1:0]  em_next;
    logic        em_done;
    logic [3:0]  rm_inc;
    logic [31:0] len_step;

    // cr lf cr lf tracker
    always_comb
    begin
        em_want = cur.end_match_count[0] ? CHAR_LF : CHAR_CR;
        em_inc  = {1'b0, cur.end_match_count} + 3'd1;
        em_done = 1'b0;
        if (data_byte == em_want)
        begin
            em_done = em_inc[2];
            em_next = em_inc[2] ? 2'd0 : em_inc[1:0];
        end
        else
        begin
            em_next = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
        end
    end

    assign rm_inc   = {1'b0, cur.range_match_count} + 4'd1;
    assign len_step = (cur.length_accum << 3) + (cur.length_accum << 1)
                      + {24'd0, data_byte} - {24'd0, ASCII_ZERO};

    always_comb
    begin
        nxt        = cur;
        enter_body = 1'b0;
        case (cur.range_line_phase)
            PH_SKIP:
            begin
                nxt.range_line_phase = PH_SLASH;
            end
            PH_SLASH:
            begin
                if (data_byte == CHAR_CR)
                begin
                    nxt.range_line_phase = PH_IDLE;
                    nxt.end_match_count  = em_next;
                    if (em_done)
                    begin
                        enter_body            = 1'b1;
                        nxt.range_match_count = 3'd0;
                    end
                end
                else if (data_byte == CHAR_SLASH)
                begin
                    nxt.range_line_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (data_byte == CHAR_CR)
                begin
                    nxt.range_line_phase = PH_IDLE;
                    nxt.end_match_count  = em_next;
                    if (em_done)
                    begin
                        enter_body            = 1'b1;
                        nxt.range_match_count = 3'd0;
                    end
                end
                else
                begin
                    nxt.length_accum = len_step;
                end
            end
            default:
            begin
                if (data_byte == range_char(cur.range_match_count)
                    && rm_inc >= RANGE_TAG_LEN)
                begin
                    // full tag seen, enter the range line
                    nxt.range_match_count = 3'd0;
                    nxt.range_line_phase  = PH_SKIP;
                    nxt.end_match_count   = 2'd0;
                end
                else
                begin
                    if (data_byte == range_char(cur.range_match_count))
                        nxt.range_match_count = rm_inc[2:0];
                    else
                        nxt.range_match_count = (data_byte == CHAR_DASH) ? 3'd1 : 3'd0;
                    nxt.end_match_count = em_next;
                    if (em_done)
                    begin
                        enter_body            = 1'b1;
                        nxt.range_match_count = 3'd0;
                        nxt.range_line_phase  = PH_IDLE;
                    end
                end
            end
        endcase
    end

endmodule

>>> rtl/hbx_checker.sv
// port-level checks for the http body extractor, bound to the top level
// depends on http_body_extract_word_checksum_core
`timescale 1ns / 1ps

module hbx_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        is_body,
    input logic        burst_start,
    input logic [31:0] write_address,
    input logic [7:0]  write_data,
    input logic        word_done,
    input logic [31:0] running_sum,
    input logic        sum_is_zero
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(running_sum)
        && $stable(write_address))
        else $error("result changed while stalled");

    a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sum_is_zero == (running_sum == 32'd0))
        else $error("sum_is_zero disagrees with running_sum");

    a_burst_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && burst_start |-> is_body)
        else $error("burst start on a header byte");

    a_word_body: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && word_done |-> is_body)
        else $error("word completed on a header byte");

    a_header_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_body |-> write_address == 32'd0 && write_data == 8'd0)
        else $error("header byte carries write address or data");

endmodule

bind http_body_extract_word_checksum_core hbx_checker u_hbx_checker (.*);
